[sv/lgcu_pkg.sv]
// ----------------------------------------------------------------------------
// lgcu_pkg
// Shared types, widths, register indexes and reset values for the growth
// cell update block.
// ----------------------------------------------------------------------------
package lgcu_pkg;

	localparam int VALUE_BITS     = 16;
	localparam int FRAC_BITS      = 12;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 16;

	typedef logic [VALUE_BITS-1:0] value_t;
	typedef logic [FRAC_BITS-1:0]  frac_t;
	typedef value_t [2:0]          column_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_THRESHOLD      = 3'd0,
		CFG_GROWTH_STEP    = 3'd1,
		CFG_CONSUMPTION    = 3'd2,
		CFG_REGROWTH       = 3'd3,
		CFG_DECAY_FRACTION = 3'd4
	} cfg_index_t;

	typedef struct packed {
		value_t threshold;
		value_t growth_step;
		value_t consumption;
		value_t regrowth;
		frac_t  decay_fraction;
	} cfg_t;

	typedef struct packed {
		column_t left;
		column_t centre;
		column_t right;
		value_t  food;
	} window_t;

	localparam value_t RST_THRESHOLD      = value_t'(2048);
	localparam value_t RST_GROWTH_STEP    = value_t'(410);
	localparam value_t RST_CONSUMPTION    = value_t'(41);
	localparam value_t RST_REGROWTH       = value_t'(8);
	localparam frac_t  RST_DECAY_FRACTION = frac_t'(410);

endpackage

[sv/lichen_growth_cell_update.sv]
// ----------------------------------------------------------------------------
// lichen_growth_cell_update
// Cell and food update of a growth automaton over a raster pixel stream.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock unless stalled and returns the update
// of the window center one pixel later, through an input register, window
// registers, one stage of rule logic and an output register. A row's last
// pixel that follows a pending pixel produces two results; the single output
// register takes them in turn while the input waits. Configuration writes
// take effect at once and must only be issued while the block is idle.
module lichen_growth_cell_update (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic [lgcu_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [lgcu_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  lgcu_pkg::value_t                     cell_above,
	input  lgcu_pkg::value_t                     cell_here,
	input  lgcu_pkg::value_t                     cell_below,
	input  lgcu_pkg::value_t                     food_here,
	input  logic                                 row_start,
	input  logic                                 row_end,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output lgcu_pkg::value_t                     new_cell,
	output lgcu_pkg::value_t                     new_food,
	output logic                                 end_of_row
);
	import lgcu_pkg::*;

	cfg_t    cfg_q;
	logic    valid_s1;
	column_t col_s1;
	value_t  food_s1;
	logic    start_s1;
	logic    end_s1;
	logic    phase_q;
	column_t left_q;
	column_t centre_q;
	value_t  food_q;
	logic    fill_q;
	logic    out_valid_q;
	value_t  cell_out_q;
	value_t  food_out_q;
	logic    last_out_q;

	logic    out_ok;
	logic    emit_mid;
	logic    has_out;
	logic    step0;
	logic    step1;
	logic    done_s1;
	logic    load_out;
	logic    last_sel;
	window_t win;
	value_t  rule_cell;
	value_t  rule_food;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold      <= RST_THRESHOLD;
			cfg_q.growth_step    <= RST_GROWTH_STEP;
			cfg_q.consumption    <= RST_CONSUMPTION;
			cfg_q.regrowth       <= RST_REGROWTH;
			cfg_q.decay_fraction <= RST_DECAY_FRACTION;
		end else if (cfg_write) begin
			case (cfg_index_t'(cfg_index))
				CFG_THRESHOLD:      cfg_q.threshold      <= cfg_data[VALUE_BITS-1:0];
				CFG_GROWTH_STEP:    cfg_q.growth_step    <= cfg_data[VALUE_BITS-1:0];
				CFG_CONSUMPTION:    cfg_q.consumption    <= cfg_data[VALUE_BITS-1:0];
				CFG_REGROWTH:       cfg_q.regrowth       <= cfg_data[VALUE_BITS-1:0];
				CFG_DECAY_FRACTION: cfg_q.decay_fraction <= cfg_data[FRAC_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	assign out_ok   = !out_valid_q || out_ready;
	assign emit_mid = !start_s1 && fill_q;
	assign has_out  = emit_mid || end_s1;
	assign step0    = valid_s1 && !phase_q && (out_ok || !has_out);
	assign step1    = valid_s1 && phase_q && out_ok;
	assign done_s1  = step1 || (step0 && !(emit_mid && end_s1));
	assign load_out = step1 || (step0 && has_out);
	assign in_ready = !valid_s1 || done_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			col_s1   <= {cell_below, cell_here, cell_above};
			food_s1  <= food_here;
			start_s1 <= row_start;
			end_s1   <= row_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= 1'b0;
			fill_q   <= 1'b0;
			left_q   <= '0;
			centre_q <= '0;
			food_q   <= '0;
		end else begin
			if (step1) begin
				phase_q <= 1'b0;
			end else if (step0 && emit_mid && end_s1) begin
				phase_q <= 1'b1;
			end
			if (step0) begin
				left_q   <= emit_mid ? centre_q : col_s1;
				centre_q <= col_s1;
				food_q   <= food_s1;
				fill_q   <= !end_s1;
			end
		end
	end

	always_comb begin
		win.left   = left_q;
		win.centre = centre_q;
		win.right  = centre_q;
		win.food   = food_q;
		last_sel   = 1'b1;
		if (!phase_q) begin
			if (emit_mid) begin
				win.right = col_s1;
				last_sel  = 1'b0;
			end else begin
				win.left   = col_s1;
				win.centre = col_s1;
				win.right  = col_s1;
				win.food   = food_s1;
			end
		end
	end

	lgcu_rule u_rule (
		.cfg       (cfg_q),
		.win       (win),
		.next_cell (rule_cell),
		.food      (rule_food)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ok) begin
			out_valid_q <= load_out;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			cell_out_q <= rule_cell;
			food_out_q <= rule_food;
			last_out_q <= last_sel;
		end
	end

	assign out_valid  = out_valid_q;
	assign new_cell   = cell_out_q;
	assign new_food   = food_out_q;
	assign end_of_row = last_out_q;

	// The second result of a row end only exists while its request is held.
	assert property (@(posedge clk) disable iff (!arst_n) phase_q |-> valid_s1)
		else $error("second result pending without a held request");

	// The window is empty while the row-end result is still owed.
	assert property (@(posedge clk) disable iff (!arst_n) phase_q |-> !fill_q)
		else $error("window not closed while the row-end result is pending");

	// The second result is a row-end result that appears at the output.
	assert property (@(posedge clk) disable iff (!arst_n)
		step1 |=> out_valid && end_of_row)
		else $error("row-end result lost");

	// A request leaves the input register only once all its results are in the output register.
	assert property (@(posedge clk) disable iff (!arst_n)
		done_s1 && has_out |=> out_valid)
		else $error("request retired without a result");

endmodule

[sv/lgcu_rule.sv]
// ----------------------------------------------------------------------------
// lgcu_rule
// Neighbor sum and the grow, consume, decay and regrow rules for the center
// pixel of one three-by-three window.
// ----------------------------------------------------------------------------
module lgcu_rule (
	input  lgcu_pkg::cfg_t    cfg,
	input  lgcu_pkg::window_t win,
	output lgcu_pkg::value_t  next_cell,
	output lgcu_pkg::value_t  food
);
	import lgcu_pkg::*;

	localparam int SUM_BITS  = VALUE_BITS + 2;
	localparam int W_BITS    = VALUE_BITS + 5;
	localparam int S_BITS    = W_BITS - 4;
	localparam int PROD_BITS = VALUE_BITS + FRAC_BITS;

	logic [SUM_BITS-1:0]   corners;
	logic [SUM_BITS-1:0]   sides;
	logic [W_BITS-1:0]     weighted;
	logic [S_BITS-1:0]     nsum;
	logic                  grow;
	logic [VALUE_BITS:0]   grown;
	value_t                y1;
	value_t                f1;
	logic [PROD_BITS-1:0]  prod;
	value_t                y2;
	logic [VALUE_BITS:0]   f_sum;

	assign corners = SUM_BITS'(win.left[0]) + SUM_BITS'(win.left[2])
		+ SUM_BITS'(win.right[0]) + SUM_BITS'(win.right[2]);
	assign sides = SUM_BITS'(win.left[1]) + SUM_BITS'(win.right[1])
		+ SUM_BITS'(win.centre[0]) + SUM_BITS'(win.centre[2]);
	assign weighted = W_BITS'(corners) + W_BITS'(sides) + W_BITS'({sides, 1'b0});
	assign nsum = weighted[W_BITS-1:4];

	assign grow  = (nsum > S_BITS'(cfg.threshold)) && (win.food > cfg.threshold);
	assign grown = {1'b0, win.centre[1]} + {1'b0, cfg.growth_step};

	always_comb begin
		if (!grow) begin
			y1 = win.centre[1];
		end else if (grown[VALUE_BITS]) begin
			y1 = '1;
		end else begin
			y1 = grown[VALUE_BITS-1:0];
		end
	end

	always_comb begin
		if (y1 > cfg.threshold) begin
			f1 = (win.food > cfg.consumption) ? win.food - cfg.consumption : '0;
		end else begin
			f1 = win.food;
		end
	end

	assign prod = PROD_BITS'(y1) * PROD_BITS'(cfg.decay_fraction);
	assign y2 = (f1 < cfg.threshold) ? y1 - prod[PROD_BITS-1:FRAC_BITS] : y1;

	assign f_sum = {1'b0, f1} + {1'b0, cfg.regrowth};

	assign next_cell = y2;
	assign food      = f_sum[VALUE_BITS] ? '1 : f_sum[VALUE_BITS-1:0];

endmodule
